FILE: hw/rtl/dsq_pkg.sv
// Shared types and constants for the dual shift queue.
package dsq_pkg;

  typedef logic [7:0] char_t;
  typedef logic [3:0] count_t;

  localparam char_t EmptyMarkReset = 8'd45;

  typedef enum logic [2:0] {
    OP_ENQ       = 3'd0,
    OP_ENQ_DROP  = 3'd1,
    OP_DEQ       = 3'd2,
    OP_ENQ_SHORT = 3'd3,
    OP_DEQ_LONG  = 3'd4
  } op_e;

  // Command to one queue lane.
  typedef struct packed {
    logic push;
    logic force_room;
    logic pop;
  } dsq_cmd_t;

  // Status of one queue lane for the current word.
  typedef struct packed {
    logic  done;
    logic  dropped;
    char_t head_q;
    char_t head_d;
    char_t tail_d;
  } dsq_stat_t;

endpackage

FILE: hw/rtl/dsq_if.sv
// Valid/ready channel interfaces for the input and result words.
interface dsq_in_if;
  logic                valid;
  logic                ready;
  logic [2:0]          op;
  logic                queue_sel;
  dsq_pkg::char_t      data_in;

  modport source (output valid, output op, output queue_sel, output data_in, input ready);
  modport sink   (input valid, input op, input queue_sel, input data_in, output ready);
endinterface

interface dsq_out_if;
  logic                valid;
  logic                ready;
  dsq_pkg::char_t      data_out;
  logic                done_res;
  logic                dropped;
  logic                used_queue;
  dsq_pkg::count_t     count_a;
  dsq_pkg::count_t     count_b;
  dsq_pkg::char_t      front_char;
  dsq_pkg::char_t      back_char;

  modport source (output valid, output data_out, output done_res, output dropped,
                  output used_queue, output count_a, output count_b,
                  output front_char, output back_char, input ready);
  modport sink   (input valid, input data_out, input done_res, input dropped,
                  input used_queue, input count_a, input count_b,
                  input front_char, input back_char, output ready);
endinterface

FILE: hw/rtl/dsq_lane.sv
// One shift-store queue: slot zero is the front, vacated slots refill with the mark.
module dsq_lane #(
  parameter int unsigned DEPTH = 10,
  localparam int unsigned FW   = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dsq_pkg::dsq_cmd_t cmd_i,
  input  dsq_pkg::char_t    char_i,
  input  dsq_pkg::char_t    mark_i,
  output logic [FW-1:0]     fill_q_o,
  output logic [FW-1:0]     fill_d_o,
  output dsq_pkg::dsq_stat_t stat_o
);
  import dsq_pkg::*;

  char_t         slots_q [DEPTH];
  char_t         slots_d [DEPTH];
  char_t         back_q, back_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [FW-1:0] widx;
  logic          full, empty, do_shift, do_write, drop;

  assign full     = (fill_q == FW'(DEPTH));
  assign empty    = (fill_q == '0);
  assign drop     = cmd_i.push && cmd_i.force_room && full;
  assign do_shift = (cmd_i.pop && !empty) || drop;
  assign do_write = cmd_i.push && (!full || cmd_i.force_room);
  // After a drop the write lands one slot lower.
  assign widx     = drop ? fill_q - FW'(1) : fill_q;
  assign fill_d   = fill_q + FW'(do_write) - FW'(do_shift);
  assign back_d   = do_write ? char_i : back_q;

  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    char_t shifted;
    if (i == DEPTH - 1) begin : g_last
      assign shifted = mark_i;
    end else begin : g_mid
      assign shifted = slots_q[i+1];
    end
    always_comb begin
      if (do_write && (widx == FW'(i))) begin
        slots_d[i] = char_i;
      end else if (do_shift) begin
        slots_d[i] = shifted;
      end else begin
        slots_d[i] = slots_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      slots_q[i] <= slots_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    back_q <= back_d;
  end

  assign fill_q_o       = fill_q;
  assign fill_d_o       = fill_d;
  assign stat_o.done    = do_write || (cmd_i.pop && !empty);
  assign stat_o.dropped = drop;
  assign stat_o.head_q  = slots_q[0];
  assign stat_o.head_d  = slots_d[0];
  assign stat_o.tail_d  = back_d;

endmodule

FILE: hw/rtl/dual_shift_queue.sv
// Top level of the dual shift queue.
// Two character queues A and B, each QUEUE_DEPTH slots deep, kept as shift
// stores with the front entry in slot zero and a separate register for the
// last entry. Every input word carries an op (enqueue, enqueue dropping the
// oldest entry when full, dequeue, enqueue into the shorter queue, dequeue
// from the longer queue; ties go to A) and returns exactly one result word.
// The whole update happens in the cycle the word is accepted and the result
// lands in an output register, so the block takes one word per clock; the
// input stalls only while that output register holds a result that the sink
// has not yet taken. The empty mark (reset 45) fills vacated slots, is
// returned for empty results and is written through cfg_we_i/cfg_wdata_i;
// the user must write it only while the block is idle (not enforced).
module dual_shift_queue #(
  parameter int unsigned QUEUE_DEPTH = 10
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  dsq_in_if.sink         in_if,
  dsq_out_if.source      out_if,
  input  logic           cfg_we_i,
  input  dsq_pkg::char_t cfg_wdata_i
);
  import dsq_pkg::*;

  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);

  char_t         mark_q;
  logic          in_acc;
  logic          sel;
  logic          is_push, is_pop;
  dsq_cmd_t      cmd, cmd_a, cmd_b;
  logic [FW-1:0] fill_a_q, fill_b_q, fill_a_d, fill_b_d;
  dsq_stat_t     stat_a, stat_b, stat_u;
  logic [FW-1:0] fill_u_d;
  logic [FW+3:0] wide_a, wide_b;

  // Output register.
  logic  out_valid_q;
  char_t data_out_q, front_q, back_q;
  logic  done_q, dropped_q, used_q;
  count_t count_a_q, count_b_q;

  // Take a new word whenever the result register is free or being drained.
  assign in_if.ready = !out_valid_q || out_if.ready;
  assign in_acc      = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q <= EmptyMarkReset;
    end else if (cfg_we_i) begin
      mark_q <= cfg_wdata_i;
    end
  end

  // Pick the queue: the two self-steering ops compare fill levels, ties to A.
  always_comb begin
    case (in_if.op)
      OP_ENQ_SHORT: sel = (fill_a_q > fill_b_q);
      OP_DEQ_LONG:  sel = (fill_a_q < fill_b_q);
      default:      sel = in_if.queue_sel;
    endcase
  end

  always_comb begin
    is_push = 1'b0;
    is_pop  = 1'b0;
    unique case (in_if.op)
      OP_ENQ, OP_ENQ_DROP, OP_ENQ_SHORT: is_push = 1'b1;
      OP_DEQ, OP_DEQ_LONG:               is_pop  = 1'b1;
      default: ;
    endcase
  end

  assign cmd.push       = in_acc && is_push;
  assign cmd.pop        = in_acc && is_pop;
  assign cmd.force_room = (in_if.op == OP_ENQ_DROP);
  assign cmd_a          = sel ? '0 : cmd;
  assign cmd_b          = sel ? cmd : '0;

  dsq_lane #(.DEPTH(QUEUE_DEPTH)) u_lane_a (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_a),
    .char_i   (in_if.data_in),
    .mark_i   (mark_q),
    .fill_q_o (fill_a_q),
    .fill_d_o (fill_a_d),
    .stat_o   (stat_a)
  );

  dsq_lane #(.DEPTH(QUEUE_DEPTH)) u_lane_b (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_b),
    .char_i   (in_if.data_in),
    .mark_i   (mark_q),
    .fill_q_o (fill_b_q),
    .fill_d_o (fill_b_d),
    .stat_o   (stat_b)
  );

  assign stat_u   = sel ? stat_b : stat_a;
  assign fill_u_d = sel ? fill_b_d : fill_a_d;
  // Report counts on four bits whatever the fill width.
  assign wide_a   = {4'b0, fill_a_d};
  assign wide_b   = {4'b0, fill_b_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      out_valid_q <= in_if.valid;
    end
  end

  // Capture the result of the accepted word; hold it otherwise.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      data_out_q <= (is_pop && stat_u.done) ? stat_u.head_q : mark_q;
      done_q     <= stat_u.done;
      dropped_q  <= stat_u.dropped;
      used_q     <= sel;
      count_a_q  <= wide_a[3:0];
      count_b_q  <= wide_b[3:0];
      front_q    <= (fill_u_d != '0) ? stat_u.head_d : mark_q;
      back_q     <= (fill_u_d != '0) ? stat_u.tail_d : mark_q;
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.data_out   = data_out_q;
  assign out_if.done_res   = done_q;
  assign out_if.dropped    = dropped_q;
  assign out_if.used_queue = used_q;
  assign out_if.count_a    = count_a_q;
  assign out_if.count_b    = count_b_q;
  assign out_if.front_char = front_q;
  assign out_if.back_char  = back_q;

endmodule

FILE: hw/rtl/dsq_check.sv
// Port-level checker for the dual shift queue, bound to the top level.
module dsq_check #(
  parameter int unsigned QUEUE_DEPTH = 10
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_ready_i,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input logic           done_res_i,
  input logic           dropped_i,
  input logic           used_queue_i,
  input dsq_pkg::count_t count_a_i,
  input dsq_pkg::count_t count_b_i,
  input dsq_pkg::char_t front_char_i,
  input dsq_pkg::char_t back_char_i
);
  import dsq_pkg::*;

  localparam int unsigned CountMax = (QUEUE_DEPTH > 15) ? 15 : QUEUE_DEPTH;

  // Stall only behind a pending result word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no pending result");

  // A held result word stays valid and keeps its front character and both counts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(front_char_i)
      && $stable(count_a_i) && $stable(count_b_i))
    else $error("stalled result changed");

  // Dropping the oldest entry always ends in a successful enqueue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && dropped_i |-> done_res_i)
    else $error("drop without completed enqueue");

  // Counts never exceed the depth when it fits the count field.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && QUEUE_DEPTH <= 15 |->
      count_a_i <= count_t'(CountMax) && count_b_i <= count_t'(CountMax))
    else $error("count beyond depth");

  // With one entry or none, front and back of the used queue agree.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ((!used_queue_i && count_a_i <= 4'd1)
      || (used_queue_i && count_b_i <= 4'd1)) && QUEUE_DEPTH <= 15
      |-> front_char_i == back_char_i)
    else $error("front and back disagree on a short queue");

endmodule

bind dual_shift_queue dsq_check #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dsq_check (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_if.ready),
  .out_valid_i  (out_if.valid),
  .out_ready_i  (out_if.ready),
  .done_res_i   (out_if.done_res),
  .dropped_i    (out_if.dropped),
  .used_queue_i (out_if.used_queue),
  .count_a_i    (out_if.count_a),
  .count_b_i    (out_if.count_b),
  .front_char_i (out_if.front_char),
  .back_char_i  (out_if.back_char)
);
